>>> sv/lpp_pkg.sv
// Shared types, constants and helper functions for the lidar point projection block.
`default_nettype none
package lpp_pkg;

	// Datapath widths.
	localparam int ACC_W   = 58;
	localparam int DEN_W   = 57;
	localparam int QBITS   = 18;
	localparam int CBITS   = 8;
	localparam int CNUM_W  = 32;
	localparam int CDEN_W  = 24;
	localparam int PIX_W   = 16;
	localparam int CFG_W   = 64;
	localparam int IDX_W   = 4;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_ROW0_A  = 4'd0;
	localparam logic [IDX_W-1:0] REG_ROW0_B  = 4'd1;
	localparam logic [IDX_W-1:0] REG_ROW1_A  = 4'd2;
	localparam logic [IDX_W-1:0] REG_ROW1_B  = 4'd3;
	localparam logic [IDX_W-1:0] REG_ROW2_A  = 4'd4;
	localparam logic [IDX_W-1:0] REG_ROW2_B  = 4'd5;
	localparam logic [IDX_W-1:0] REG_LIMITS  = 4'd6;
	localparam logic [IDX_W-1:0] REG_OFFSETS = 4'd7;

	// Reset values: x_min 1.5 m, x_max 100 m, full scale 10 m; column offset 20.
	localparam logic [47:0] LIMITS_RST  = 48'h0A00_6400_0180;
	localparam logic [31:0] OFFSETS_RST = 32'd20;

	localparam logic [7:0] COLOR_MAX = 8'd255;

	// One item inside the divider pipeline.
	typedef struct packed {
		logic [ACC_W-1:0]  u_rem;
		logic [ACC_W-1:0]  v_rem;
		logic [QBITS-1:0]  u_q;
		logic [QBITS-1:0]  v_q;
		logic [DEN_W-1:0]  den;
		logic              u_neg;
		logic              v_neg;
		logic              u_sat;
		logic              v_sat;
		logic [CNUM_W-1:0] c_rem;
		logic [CBITS-1:0]  c_q;
		logic [CDEN_W-1:0] c_den;
		logic              c_full;
		logic [7:0]        blue;
	} div_st_t;

	// Signed quotient plus offset, saturated to a 16-bit pixel coordinate.
	function automatic logic [PIX_W-1:0] pix_sat(input logic [QBITS-1:0] q,
			input logic neg, input logic sat, input logic [PIX_W-1:0] off);
		logic [QBITS-1:0]    qm;
		logic signed [QBITS:0]   sq;
		logic signed [QBITS+1:0] sum;
		qm  = sat ? {QBITS{1'b1}} : q;
		sq  = neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
		sum = (QBITS+2)'(sq) + (QBITS+2)'($signed(off));
		if (sum > (QBITS+2)'(32767))
			return 16'h7FFF;
		else if (sum < -(QBITS+2)'(32768))
			return 16'h8000;
		else
			return sum[PIX_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> sv/lpp_point_if.sv
// Input channel carrying one lidar point per beat.
`default_nettype none
interface lpp_point_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [7:0]        reflectivity;

	modport source(output valid, point_x, point_y, point_z, reflectivity, input ready);
	modport sink(input valid, point_x, point_y, point_z, reflectivity, output ready);
endinterface
`default_nettype wire

>>> sv/lpp_pixel_if.sv
// Output channel carrying one colored pixel per beat.
`default_nettype none
interface lpp_pixel_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] pixel_u;
	logic signed [15:0] pixel_v;
	logic [7:0]        blue;
	logic [7:0]        green;
	logic [7:0]        red;

	modport source(output valid, pixel_u, pixel_v, blue, green, red, input ready);
	modport sink(input valid, pixel_u, pixel_v, blue, green, red, output ready);
endinterface
`default_nettype wire

>>> sv/lpp_front.sv
// Front pipeline: range filter, matrix products, row sums and divider setup.
`default_nettype none
module lpp_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       in_valid,
	input  wire logic [31:0]                in_x,
	input  wire logic [31:0]                in_y,
	input  wire logic [31:0]                in_z,
	input  wire logic [7:0]                 in_refl,
	input  wire logic [2:0][3:0][31:0]      coef,
	input  wire logic [47:0]                limits,
	output logic                            out_valid,
	output lpp_pkg::div_st_t                out_st
);
	localparam int AW = lpp_pkg::ACC_W;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][31:0]  xyz_s1;
	logic [7:0]        refl_s1, refl_s2, refl_s3, refl_s4;
	logic signed [63:0] p_s2 [3][3];
	logic [32:0]       gap_s2;
	logic              full_s2, full_s3, full_s4;
	logic signed [AW-1:0] s01_s3 [3];
	logic signed [AW-1:0] s23_s3 [3];
	logic [31:0]       cnum_s3, cnum_s4;
	logic signed [AW-1:0] acc_s4 [3];
	lpp_pkg::div_st_t  st_s5;

	logic signed [32:0] xs, xmin, xmax;
	logic signed [33:0] diff;
	logic [32:0]       gap;
	logic [AW-1:0]     u_abs, v_abs;
	logic              keep;

	// Range window on the forward coordinate.
	always_comb begin
		xs   = 33'($signed(in_x));
		xmin = $signed({1'b0, limits[15:0], 16'h0} >> 8);
		xmax = $signed({1'b0, limits[31:16], 16'h0} >> 8);
		keep = (xs >= xmin) && (xs <= xmax);
	end

	// Distance from the color full scale.
	always_comb begin
		diff = 34'($signed(xyz_s1[0])) - $signed({10'b0, limits[47:32], 8'h0});
		gap  = diff[33] ? 33'(-diff) : diff[32:0];
	end

	// Magnitudes of the two numerators.
	always_comb begin
		u_abs = acc_s4[0][AW-1] ? AW'(-acc_s4[0]) : AW'(acc_s4[0]);
		v_abs = acc_s4[1][AW-1] ? AW'(-acc_s4[1]) : AW'(acc_s4[1]);
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid & keep;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 & ~acc_s4[2][AW-1] & (acc_s4[2] != '0);
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			xyz_s1  <= {in_z, in_y, in_x};
			refl_s1 <= in_refl;

			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					p_s2[r][c] <= $signed(coef[r][c]) * $signed(xyz_s1[c]);
			gap_s2  <= gap;
			full_s2 <= (gap >= {9'b0, limits[47:32], 8'h0});
			refl_s2 <= refl_s1;

			for (int r = 0; r < 3; r++) begin
				s01_s3[r] <= AW'(p_s2[r][0] >>> 8) + AW'(p_s2[r][1] >>> 8);
				s23_s3[r] <= AW'(p_s2[r][2] >>> 8)
					+ (AW'($signed(coef[r][3])) <<< 8);
			end
			cnum_s3 <= ({gap_s2[23:0], 8'h0}) - {8'h0, gap_s2[23:0]};
			full_s3 <= full_s2;
			refl_s3 <= refl_s2;

			for (int r = 0; r < 3; r++)
				acc_s4[r] <= s01_s3[r] + s23_s3[r];
			cnum_s4 <= cnum_s3;
			full_s4 <= full_s3;
			refl_s4 <= refl_s3;

			st_s5.u_rem  <= u_abs;
			st_s5.v_rem  <= v_abs;
			st_s5.u_q    <= '0;
			st_s5.v_q    <= '0;
			st_s5.den    <= acc_s4[2][lpp_pkg::DEN_W-1:0];
			st_s5.u_neg  <= acc_s4[0][AW-1];
			st_s5.v_neg  <= acc_s4[1][AW-1];
			st_s5.u_sat  <= {18'b0, u_abs}
				>= ({19'b0, acc_s4[2][lpp_pkg::DEN_W-1:0]} << lpp_pkg::QBITS);
			st_s5.v_sat  <= {18'b0, v_abs}
				>= ({19'b0, acc_s4[2][lpp_pkg::DEN_W-1:0]} << lpp_pkg::QBITS);
			st_s5.c_rem  <= cnum_s4;
			st_s5.c_q    <= '0;
			st_s5.c_den  <= {limits[47:32], 8'h0};
			st_s5.c_full <= full_s4;
			st_s5.blue   <= refl_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_st    = st_s5;

endmodule
`default_nettype wire

>>> sv/lpp_div.sv
// Restoring divider, one U/D and V/D quotient bit per stage; color ramp in stages 0 to 7.
`default_nettype none
module lpp_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  lpp_pkg::div_st_t      in_st,
	output logic                  out_valid,
	output lpp_pkg::div_st_t      out_st
);
	localparam int QB = lpp_pkg::QBITS;
	localparam int CB = lpp_pkg::CBITS;
	localparam int WW = lpp_pkg::ACC_W + QB;

	lpp_pkg::div_st_t stage_s [QB];
	logic             vld_s   [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int J  = QB - 1 - k;
		localparam int CS = (k < CB) ? CB - 1 - k : 0;
		lpp_pkg::div_st_t prv, nxt;
		logic             pv;
		logic [WW-1:0]    dsh;

		assign prv = (k == 0) ? in_st : stage_s[(k == 0) ? 0 : k - 1];
		assign pv  = (k == 0) ? in_valid : vld_s[(k == 0) ? 0 : k - 1];

		// One quotient bit for each pixel axis, and for the color while its bits last.
		always_comb begin
			nxt = prv;
			dsh = {{(WW - lpp_pkg::DEN_W){1'b0}}, prv.den} << J;
			if ({{QB{1'b0}}, prv.u_rem} >= dsh) begin
				nxt.u_rem = prv.u_rem - dsh[lpp_pkg::ACC_W-1:0];
				nxt.u_q[J] = 1'b1;
			end
			if ({{QB{1'b0}}, prv.v_rem} >= dsh) begin
				nxt.v_rem = prv.v_rem - dsh[lpp_pkg::ACC_W-1:0];
				nxt.v_q[J] = 1'b1;
			end
			if (k < CB) begin
				if (prv.c_rem >= ({8'b0, prv.c_den} << CS)) begin
					nxt.c_rem = prv.c_rem - ({8'b0, prv.c_den} << CS);
					nxt.c_q[CS] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (adv)
				vld_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (adv)
				stage_s[k] <= nxt;
		end
	end

	assign out_valid = vld_s[QB-1];
	assign out_st    = stage_s[QB-1];

endmodule
`default_nettype wire

>>> sv/lidar_point_to_pixel_projection_top.sv
// Top level of the lidar point to pixel projection block.
// Takes one point per clock while input ready is high. For points inside the x window
// with positive depth it presents one pixel beat after five front
// stages (window check, nine 32x32 products, two adder levels, divider setup), 18
// divider stages that each resolve one quotient bit of U/D and V/D (the first eight
// also resolve the color ramp), and the output register. Dropped points leave no
// beat. A two-entry output buffer keeps points flowing while one result waits; input
// ready drops only when both entries are full. Configuration writes take effect at
// once and are expected while the pipeline is empty.
`default_nettype none
module lidar_point_to_pixel_projection_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	lpp_point_if.sink                          pt,
	lpp_pixel_if.source                        px,
	input  wire logic                          cfg_we,
	input  wire logic [lpp_pkg::IDX_W-1:0]     cfg_idx,
	input  wire logic [lpp_pkg::CFG_W-1:0]     cfg_data
);
	logic [5:0][63:0] mat_q;
	logic [47:0]      lim_q;
	logic [31:0]      off_q;
	logic [2:0][3:0][31:0] coef;

	logic             adv;
	logic             fr_valid, dv_valid;
	lpp_pkg::div_st_t fr_st, dv_st;

	logic [15:0] fin_u, fin_v;
	logic [7:0]  fin_r, fin_g;
	logic [55:0] out_q, skid_data_q;
	logic        out_vld_q, skid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
			lim_q <= lpp_pkg::LIMITS_RST;
			off_q <= lpp_pkg::OFFSETS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				lpp_pkg::REG_ROW0_A:  mat_q[0] <= cfg_data;
				lpp_pkg::REG_ROW0_B:  mat_q[1] <= cfg_data;
				lpp_pkg::REG_ROW1_A:  mat_q[2] <= cfg_data;
				lpp_pkg::REG_ROW1_B:  mat_q[3] <= cfg_data;
				lpp_pkg::REG_ROW2_A:  mat_q[4] <= cfg_data;
				lpp_pkg::REG_ROW2_B:  mat_q[5] <= cfg_data;
				lpp_pkg::REG_LIMITS:  lim_q    <= cfg_data[47:0];
				lpp_pkg::REG_OFFSETS: off_q    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Split each 64-bit word into its two coefficients.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			coef[r][0] = mat_q[2*r][31:0];
			coef[r][1] = mat_q[2*r][63:32];
			coef[r][2] = mat_q[2*r+1][31:0];
			coef[r][3] = mat_q[2*r+1][63:32];
		end
	end

	// The whole pipeline moves unless the output buffer is full.
	assign adv      = ~skid_q;
	assign pt.ready = adv;

	lpp_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(pt.valid), .in_x(pt.point_x), .in_y(pt.point_y),
		.in_z(pt.point_z), .in_refl(pt.reflectivity),
		.coef(coef), .limits(lim_q),
		.out_valid(fr_valid), .out_st(fr_st)
	);

	lpp_div u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(fr_valid), .in_st(fr_st),
		.out_valid(dv_valid), .out_st(dv_st)
	);

	// Sign, offset and saturation of the pixel; color from the ramp quotient.
	always_comb begin
		fin_u = lpp_pkg::pix_sat(dv_st.u_q, dv_st.u_neg, dv_st.u_sat, off_q[15:0]);
		fin_v = lpp_pkg::pix_sat(dv_st.v_q, dv_st.v_neg, dv_st.v_sat, off_q[31:16]);
		fin_r = dv_st.c_full ? lpp_pkg::COLOR_MAX : dv_st.c_q;
		fin_g = dv_st.c_full ? 8'd0
			: lpp_pkg::COLOR_MAX - dv_st.c_q - {7'b0, (dv_st.c_rem != '0)};
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_q    <= 1'b0;
		end else if (out_vld_q && !px.ready) begin
			if (adv && dv_valid)
				skid_q <= 1'b1;
		end else if (skid_q) begin
			out_vld_q <= 1'b1;
			skid_q    <= 1'b0;
		end else begin
			out_vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && !px.ready) begin
			if (adv && dv_valid)
				skid_data_q <= {fin_u, fin_v, dv_st.blue, fin_g, fin_r};
		end else if (skid_q) begin
			out_q <= skid_data_q;
		end else begin
			out_q <= {fin_u, fin_v, dv_st.blue, fin_g, fin_r};
		end
	end

	assign px.valid   = out_vld_q;
	assign px.pixel_u = out_q[55:40];
	assign px.pixel_v = out_q[39:24];
	assign px.blue    = out_q[23:16];
	assign px.green   = out_q[15:8];
	assign px.red     = out_q[7:0];

	// The skid entry only fills behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |-> out_vld_q) else $error("skid entry full with empty output register");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_q) |-> $past(out_vld_q && !px.ready && dv_valid))
		else $error("skid entry filled without a stalled result");

	a_stall_input: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |-> !pt.ready) else $error("input taken while output buffer is full");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_q && px.ready) |=> (out_vld_q && !skid_q))
		else $error("skid entry not moved forward");

endmodule
`default_nettype wire
